[rtl/qvr_pkg.sv]
// Package for the quaternion vector rotator: widths, register indexes,
// reset constants and the item and coefficient types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;

    localparam int VEC_W   = 24;                 // vector component width
    localparam int QUAT_W  = 16;                 // quaternion component width
    localparam int CIDX_W  = 8;                  // config register index width
    localparam int PROD_W  = 2 * QUAT_W;         // one quaternion product
    localparam int MAT_W   = PROD_W + 2;         // matrix entry, signed
    localparam int NRM_W   = PROD_W + 1;         // norm, unsigned
    localparam int VPROD_W = MAT_W + VEC_W;      // entry times component
    localparam int ACC_W   = VPROD_W + 2;        // sum of three products
    localparam int QUO_W   = VEC_W + 2;          // quotient bits before rounding
    localparam int IQ_DEPTH = 4;                 // input queue depth
    localparam int IQ_AW    = $clog2(IQ_DEPTH);
    localparam int OQ_DEPTH = 32;                // output queue depth
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic [CIDX_W-1:0] REG_QUAT_X = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_QUAT_Y = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] REG_QUAT_Z = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_QUAT_W = CIDX_W'(3);

    localparam logic signed [QUAT_W-1:0] QUAT_W_RST = QUAT_W'(32767);
    localparam logic signed [PROD_W-1:0] WW_RST =
        PROD_W'(QUAT_W_RST) * PROD_W'(QUAT_W_RST);

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [MAT_W-1:0] m00;
        logic signed [MAT_W-1:0] m01;
        logic signed [MAT_W-1:0] m02;
        logic signed [MAT_W-1:0] m10;
        logic signed [MAT_W-1:0] m11;
        logic signed [MAT_W-1:0] m12;
        logic signed [MAT_W-1:0] m20;
        logic signed [MAT_W-1:0] m21;
        logic signed [MAT_W-1:0] m22;
        logic [NRM_W-1:0]        n;
    } coef_t;

endpackage
`default_nettype wire

[rtl/qvr_coef.sv]
// Quaternion registers and the two-stage precompute of the unnormalized
// rotation matrix and norm. Depends on qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qvr_coef
    import qvr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [QUAT_W-1:0] cfg_data,
    output coef_t                  coef
);

    logic signed [QUAT_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    coef_t coef_reg, coef_next;
    logic signed [MAT_W-1:0] nsum;

    function automatic logic signed [PROD_W-1:0] qmul(
        input logic signed [QUAT_W-1:0] a,
        input logic signed [QUAT_W-1:0] b
    );
        qmul = PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic logic signed [MAT_W-1:0] ext(input logic signed [PROD_W-1:0] a);
        ext = MAT_W'(a);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= QUAT_W_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_QUAT_X: qx_reg <= cfg_data;
                REG_QUAT_Y: qy_reg <= cfg_data;
                REG_QUAT_Z: qz_reg <= cfg_data;
                REG_QUAT_W: qw_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: the ten quaternion products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xx_reg <= '0; yy_reg <= '0; zz_reg <= '0; ww_reg <= WW_RST;
            xy_reg <= '0; xz_reg <= '0; yz_reg <= '0;
            wx_reg <= '0; wy_reg <= '0; wz_reg <= '0;
        end
        else
        begin
            xx_reg <= qmul(qx_reg, qx_reg);
            yy_reg <= qmul(qy_reg, qy_reg);
            zz_reg <= qmul(qz_reg, qz_reg);
            ww_reg <= qmul(qw_reg, qw_reg);
            xy_reg <= qmul(qx_reg, qy_reg);
            xz_reg <= qmul(qx_reg, qz_reg);
            yz_reg <= qmul(qy_reg, qz_reg);
            wx_reg <= qmul(qw_reg, qx_reg);
            wy_reg <= qmul(qw_reg, qy_reg);
            wz_reg <= qmul(qw_reg, qz_reg);
        end
    end

    // stage 2: matrix entries; a zero quaternion becomes identity over one
    always_comb
    begin
        nsum = ext(ww_reg) + ext(xx_reg) + ext(yy_reg) + ext(zz_reg);
        coef_next.m00 = ext(ww_reg) + ext(xx_reg) - ext(yy_reg) - ext(zz_reg);
        coef_next.m01 = (ext(xy_reg) - ext(wz_reg)) <<< 1;
        coef_next.m02 = (ext(xz_reg) + ext(wy_reg)) <<< 1;
        coef_next.m10 = (ext(xy_reg) + ext(wz_reg)) <<< 1;
        coef_next.m11 = ext(ww_reg) - ext(xx_reg) + ext(yy_reg) - ext(zz_reg);
        coef_next.m12 = (ext(yz_reg) - ext(wx_reg)) <<< 1;
        coef_next.m20 = (ext(xz_reg) - ext(wy_reg)) <<< 1;
        coef_next.m21 = (ext(yz_reg) + ext(wx_reg)) <<< 1;
        coef_next.m22 = ext(ww_reg) - ext(xx_reg) - ext(yy_reg) + ext(zz_reg);
        coef_next.n   = nsum[NRM_W-1:0];
        if (nsum == '0)
        begin
            coef_next     = '0;
            coef_next.m00 = MAT_W'(1);
            coef_next.m11 = MAT_W'(1);
            coef_next.m22 = MAT_W'(1);
            coef_next.n   = NRM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg     <= '0;
            coef_reg.m00 <= MAT_W'(WW_RST);
            coef_reg.m11 <= MAT_W'(WW_RST);
            coef_reg.m22 <= MAT_W'(WW_RST);
            coef_reg.n   <= NRM_W'(WW_RST);
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule
`default_nettype wire

[rtl/qvr_front.sv]
// Front end: accepts vector items into a short queue for the back end.
// Depends on qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qvr_front
    import qvr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             vec_valid,
    output logic                  vec_stall,
    input  wire logic [VEC_W-1:0] vec_x,
    input  wire logic [VEC_W-1:0] vec_y,
    input  wire logic [VEC_W-1:0] vec_z,
    output logic                  head_valid,
    output vec_t                  head,
    input  wire logic             head_take
);

    vec_t               mem_reg [IQ_DEPTH];
    logic [IQ_AW-1:0]   wr_reg, rd_reg;
    logic [IQ_AW:0]     cnt_reg;
    logic               push, pop;

    assign vec_stall  = (cnt_reg == (IQ_AW+1)'(IQ_DEPTH));
    assign push       = vec_valid && !vec_stall;
    assign pop        = head_take && head_valid;
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= '{x: vec_x, y: vec_y, z: vec_z};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (IQ_AW+1)'(push) - (IQ_AW+1)'(pop);
        end
    end

endmodule
`default_nettype wire

[rtl/qvr_back.sv]
// Back end: matrix product, pipelined restoring divide by the norm, rounding,
// saturation and the credit-managed output queue. Depends on qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qvr_back
    import qvr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire coef_t            coef,
    input  wire logic             head_valid,
    input  wire vec_t             head,
    output logic                  head_take,
    output logic                  rot_valid,
    input  wire logic             rot_stall,
    output logic [VEC_W-1:0]      rot_x,
    output logic [VEC_W-1:0]      rot_y,
    output logic [VEC_W-1:0]      rot_z
);

    localparam logic [QUO_W:0] HALF = (QUO_W+1)'(1) << (VEC_W - 1);

    logic signed [MAT_W-1:0]   mat [3][3];
    logic signed [VEC_W-1:0]   vin [3];
    logic signed [VPROD_W-1:0] prod_reg [3][3];
    logic                      s1_vld_reg;
    logic [NRM_W-1:0]          dr_reg  [3][QUO_W+1];
    logic [QUO_W-1:0]          dw_reg  [3][QUO_W+1];
    logic                      neg_reg [3][QUO_W+1];
    logic                      dv_reg  [QUO_W+1];
    logic [VEC_W-1:0]          res [3];

    vec_t               oq_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   owr_reg, ord_reg;
    logic [OQ_AW:0]     ocnt_reg, infl_reg;
    logic               oq_push, oq_pop;

    assign mat[0][0] = coef.m00; assign mat[0][1] = coef.m01; assign mat[0][2] = coef.m02;
    assign mat[1][0] = coef.m10; assign mat[1][1] = coef.m11; assign mat[1][2] = coef.m12;
    assign mat[2][0] = coef.m20; assign mat[2][1] = coef.m21; assign mat[2][2] = coef.m22;
    assign vin[0] = head.x;
    assign vin[1] = head.y;
    assign vin[2] = head.z;

    // take only while the output queue is sure to have room for it
    assign head_take = head_valid
        && ((OQ_AW+2)'(ocnt_reg) + (OQ_AW+2)'(infl_reg) < (OQ_AW+2)'(OQ_DEPTH));

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[r][c] <= VPROD_W'(mat[r][c]) * VPROD_W'(vin[c]);
            end
        end
    end

    // sum, sign/magnitude and the first divide stage, then one quotient bit a stage
    always_ff @(posedge clk)
    begin : div_pipe
        logic signed [ACC_W-1:0] acc;
        logic [ACC_W-1:0]        mag;
        logic [NRM_W:0]          t;
        logic                    ge;
        for (int r = 0; r < 3; r++)
        begin
            acc = ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1])
                + ACC_W'(prod_reg[r][2]);
            mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
            neg_reg[r][0] <= acc[ACC_W-1];
            dr_reg[r][0]  <= NRM_W'(mag >> QUO_W);
            dw_reg[r][0]  <= mag[QUO_W-1:0];
            for (int k = 0; k < QUO_W; k++)
            begin
                t  = {dr_reg[r][k], dw_reg[r][k][QUO_W-1]};
                ge = (t >= {1'b0, coef.n});
                dr_reg[r][k+1]  <= ge ? NRM_W'(t - {1'b0, coef.n}) : t[NRM_W-1:0];
                dw_reg[r][k+1]  <= {dw_reg[r][k][QUO_W-2:0], ge};
                neg_reg[r][k+1] <= neg_reg[r][k];
            end
        end
    end

    // round half away from zero, then saturate
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            logic           rb;
            logic [QUO_W:0] q, lim, m;
            rb  = ({dr_reg[r][QUO_W], 1'b0} >= {1'b0, coef.n});
            q   = (QUO_W+1)'(dw_reg[r][QUO_W]) + (QUO_W+1)'(rb);
            lim = neg_reg[r][QUO_W] ? HALF : HALF - 1'b1;
            m   = (q > lim) ? lim : q;
            res[r] = neg_reg[r][QUO_W] ? VEC_W'(-m) : VEC_W'(m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            for (int k = 0; k <= QUO_W; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            s1_vld_reg <= head_take;
            dv_reg[0]  <= s1_vld_reg;
            for (int k = 0; k < QUO_W; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
    end

    assign oq_push = dv_reg[QUO_W];
    assign oq_pop  = rot_valid && !rot_stall;

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[owr_reg] <= '{x: res[0], y: res[1], z: res[2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
            infl_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                owr_reg <= owr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                ord_reg <= ord_reg + 1'b1;
            end
            ocnt_reg <= ocnt_reg + (OQ_AW+1)'(oq_push) - (OQ_AW+1)'(oq_pop);
            infl_reg <= infl_reg + (OQ_AW+1)'(head_take) - (OQ_AW+1)'(oq_push);
        end
    end

    assign rot_valid = (ocnt_reg != '0);
    assign rot_x     = oq_reg[ord_reg].x;
    assign rot_y     = oq_reg[ord_reg].y;
    assign rot_z     = oq_reg[ord_reg].z;

endmodule
`default_nettype wire

[rtl/quaternion_vector_rotate_top.sv]
// Throughput: one item per cycle while the output queue has room, set by the fully
// pipelined product and divide. The divide by the norm takes one quotient bit per
// stage, 26 stages per lane. Reset (rst_n, async, active low) empties both queues
// and loads the identity quaternion (w = 32767, x = y = z = 0); config reaches the
// matrix through the quaternion, product and matrix registers.
// Top level: wires config registers, front queue and back-end datapath. Uses qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_vector_rotate_top
    import qvr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [QUAT_W-1:0] cfg_data,
    // input vector items
    input  wire logic              vec_valid,
    output logic                   vec_stall,
    input  wire logic [VEC_W-1:0]  vec_x,
    input  wire logic [VEC_W-1:0]  vec_y,
    input  wire logic [VEC_W-1:0]  vec_z,
    // rotated vector items
    output logic                   rot_valid,
    input  wire logic              rot_stall,
    output logic [VEC_W-1:0]       rot_x,
    output logic [VEC_W-1:0]       rot_y,
    output logic [VEC_W-1:0]       rot_z
);

    coef_t coef;        // matrix, norm; user keeps constant while items flow; unenforced
    vec_t  head;        // oldest queued item
    logic  head_valid;
    logic  head_take;

    // quaternion registers; a zero quaternion is turned into identity here
    qvr_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // front: short queue decoupling vec_stall from the back end
    qvr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vec_valid  (vec_valid),
        .vec_stall  (vec_stall),
        .vec_x      (vec_x),
        .vec_y      (vec_y),
        .vec_z      (vec_z),
        .head_valid (head_valid),
        .head       (head),
        .head_take  (head_take)
    );

    // back: multiply, divide, round, saturate; the output queue absorbs rot_stall
    qvr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef),
        .head_valid (head_valid),
        .head       (head),
        .head_take  (head_take),
        .rot_valid  (rot_valid),
        .rot_stall  (rot_stall),
        .rot_x      (rot_x),
        .rot_y      (rot_y),
        .rot_z      (rot_z)
    );

endmodule
`default_nettype wire

[rtl/qvr_checker.sv]
// Port-level checks for the quaternion vector rotator, bound to the top level.
// Depends on qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qvr_port_checks
    import qvr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic              vec_valid,
    input wire logic              vec_stall,
    input wire logic              rot_valid,
    input wire logic              rot_stall,
    input wire logic [VEC_W-1:0]  rot_x,
    input wire logic [VEC_W-1:0]  rot_y,
    input wire logic [VEC_W-1:0]  rot_z
);

    // a stalled result item holds
    a_rot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && rot_stall |=> rot_valid && $stable(rot_x) && $stable(rot_y)
            && $stable(rot_z))
        else $error("stalled result item changed");

    // config registers never back-pressure
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not ready");

    // the input queue only fills on an accepted item
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !(vec_valid && !vec_stall) |=> !$rose(vec_stall))
        else $error("vec_stall rose without an accepted item");

endmodule

bind quaternion_vector_rotate_top qvr_port_checks u_qvr_port_checks (.*);
`default_nettype wire

[sim/qvr_checker.sv]
// Scoreboard for the quaternion vector rotator: tracks config writes, predicts
// each rotated item and compares it with the block's output. Uses qvr_pkg.
`timescale 1ns / 1ps
module qvr_checker
    import qvr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [QUAT_W-1:0] cfg_data,
    input  wire logic              vec_valid,
    input  wire logic              vec_stall,
    input  wire logic [VEC_W-1:0]  vec_x,
    input  wire logic [VEC_W-1:0]  vec_y,
    input  wire logic [VEC_W-1:0]  vec_z,
    input  wire logic              rot_valid,
    input  wire logic              rot_stall,
    input  wire logic [VEC_W-1:0]  rot_x,
    input  wire logic [VEC_W-1:0]  rot_y,
    input  wire logic [VEC_W-1:0]  rot_z,
    output int                     fail_count,
    output int                     pending
);

    logic signed [QUAT_W-1:0] qx, qy, qz, qw;
    vec_t rotated_q[$];

    // one output lane: row dot vector over the norm, round half away, saturate
    function automatic logic [VEC_W-1:0] lane(longint m0, longint m1, longint m2,
                                              longint v0, longint v1, longint v2,
                                              longint n);
        longint acc;
        longint mag;
        longint q;
        longint lim;
        bit neg;
        acc = m0 * v0 + m1 * v1 + m2 * v2;
        neg = acc < 0;
        mag = neg ? -acc : acc;
        q = mag / n;
        if (2 * (mag % n) >= n)
            q = q + 1;
        lim = neg ? (longint'(1) <<< (VEC_W - 1)) : (longint'(1) <<< (VEC_W - 1)) - 1;
        if (q > lim)
            q = lim;
        return neg ? VEC_W'(-q) : VEC_W'(q);
    endfunction

    function automatic vec_t rotate_vec(vec_t v);
        longint x, y, z, w, n, a, b, c;
        vec_t r;
        x = longint'(qx);
        y = longint'(qy);
        z = longint'(qz);
        w = longint'(qw);
        a = longint'(v.x);
        b = longint'(v.y);
        c = longint'(v.z);
        n = w * w + x * x + y * y + z * z;
        if (n == 0)
            return v;
        r.x = lane(w*w + x*x - y*y - z*z, 2*(x*y - w*z), 2*(x*z + w*y), a, b, c, n);
        r.y = lane(2*(x*y + w*z), w*w - x*x + y*y - z*z, 2*(y*z - w*x), a, b, c, n);
        r.z = lane(2*(x*z - w*y), 2*(y*z + w*x), w*w - x*x - y*y + z*z, a, b, c, n);
        return r;
    endfunction

    assign pending = rotated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        vec_t v;
        vec_t exp_v;
        if (!rst_n)
        begin
            qx = '0;
            qy = '0;
            qz = '0;
            qw = QUAT_W_RST;
            rotated_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_QUAT_X: qx = cfg_data;
                    REG_QUAT_Y: qy = cfg_data;
                    REG_QUAT_Z: qz = cfg_data;
                    REG_QUAT_W: qw = cfg_data;
                    default: ;
                endcase
            end
            if (vec_valid && !vec_stall)
            begin
                v.x = vec_x;
                v.y = vec_y;
                v.z = vec_z;
                rotated_q.push_back(rotate_vec(v));
            end
            if (rot_valid && !rot_stall)
            begin
                if (rotated_q.size() == 0)
                begin
                    $error("unexpected item: rot_x %0d rot_y %0d rot_z %0d",
                           $signed(rot_x), $signed(rot_y), $signed(rot_z));
                    fail_count++;
                end
                else
                begin
                    exp_v = rotated_q.pop_front();
                    if (rot_x !== exp_v.x)
                    begin
                        $error("rot_x expected %0d actual %0d", exp_v.x, $signed(rot_x));
                        fail_count++;
                    end
                    if (rot_y !== exp_v.y)
                    begin
                        $error("rot_y expected %0d actual %0d", exp_v.y, $signed(rot_y));
                        fail_count++;
                    end
                    if (rot_z !== exp_v.z)
                    begin
                        $error("rot_z expected %0d actual %0d", exp_v.z, $signed(rot_z));
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_top.sv]
// Testbench top for the quaternion vector rotator: clock, reset, stimulus and
// verdict. Depends on qvr_pkg, quaternion_vector_rotate_top and qvr_checker.
`timescale 1ns / 1ps
module tb_top
    import qvr_pkg::*;
();

    localparam int SETTLE_CYCLES = 40;     // margin for the pipeline to drain
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 96;
    localparam logic [CIDX_W-1:0] REG_FIRST_BAD = REG_QUAT_W + CIDX_W'(1);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [QUAT_W-1:0] cfg_data = '0;
    logic vec_valid = 1'b0;
    logic vec_stall;
    logic [VEC_W-1:0] vec_x = '0;
    logic [VEC_W-1:0] vec_y = '0;
    logic [VEC_W-1:0] vec_z = '0;
    logic rot_valid;
    logic rot_stall = 1'b0;
    logic [VEC_W-1:0] rot_x, rot_y, rot_z;
    int fail_count;
    int pending;

    // idling controls shared between the sender and the receiver
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    quaternion_vector_rotate_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .vec_valid(vec_valid), .vec_stall(vec_stall),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .rot_valid(rot_valid), .rot_stall(rot_stall),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
    );

    qvr_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .vec_valid(vec_valid), .vec_stall(vec_stall),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .rot_valid(rot_valid), .rot_stall(rot_stall),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
        .fail_count(fail_count), .pending(pending)
    );

    // mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // vector component: full range, an edge value, or something small
    function automatic logic [VEC_W-1:0] rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return VEC_W'($urandom);
        if (r < 7)
        begin
            case ($urandom_range(0, 4))
                0: return {1'b1, {(VEC_W-1){1'b0}}};
                1: return {1'b0, {(VEC_W-1){1'b1}}};
                2: return '0;
                3: return '1;
                default: return VEC_W'(1);
            endcase
        end
        return VEC_W'($urandom_range(0, 2000) - 1000);
    endfunction

    // valid stays up across back-to-back writes; load_quat drops it at the end
    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [QUAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // offer one item; valid stays up into the next item when there is no gap
    task automatic send_vec(logic [VEC_W-1:0] x, logic [VEC_W-1:0] y,
                            logic [VEC_W-1:0] z);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            vec_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        vec_valid <= 1'b1;
        vec_x <= x;
        vec_y <= y;
        vec_z <= z;
        do @(posedge clk); while (vec_stall);
    endtask

    // block is idle only once every expected item is back and the pipe drained
    task automatic wait_idle();
        vec_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_quat(logic [QUAT_W-1:0] x, logic [QUAT_W-1:0] y,
                             logic [QUAT_W-1:0] z, logic [QUAT_W-1:0] w);
        cfg_write(REG_QUAT_X, x);
        cfg_write(REG_QUAT_Y, y);
        // a write to an unused index must leave the quaternion alone
        if ($urandom_range(0, 1))
            cfg_write(CIDX_W'($urandom_range(32'(REG_FIRST_BAD), (1 << CIDX_W) - 1)),
                      QUAT_W'($urandom));
        cfg_write(REG_QUAT_Z, z);
        cfg_write(REG_QUAT_W, w);
        cfg_valid <= 1'b0;
        // writes reach the matrix through the quaternion, product and matrix registers
        repeat (4) @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                rot_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                rot_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    rot_stall <= 1'b1;
                    repeat (g) @(posedge clk);
                    rot_stall <= 1'b0;
                end
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // stimulus
    initial
    begin
        logic [VEC_W-1:0] vmin;
        logic [VEC_W-1:0] vmax;
        logic [QUAT_W-1:0] qa, qb, qc, qd;
        vmin = {1'b1, {(VEC_W-1){1'b0}}};
        vmax = {1'b0, {(VEC_W-1){1'b1}}};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset quaternion (identity): edges of the vector range
        send_vec('0, '0, '0);
        send_vec(vmax, vmax, vmax);
        send_vec(vmin, vmin, vmin);
        send_vec(vmin, vmax, '1);
        send_vec(VEC_W'(1), '1, '0);
        wait_idle();

        // zero quaternion passes the vector through
        load_quat('0, '0, '0, '0);
        send_vec(vmin, vmax, VEC_W'(12345));
        send_vec('1, '0, VEC_W'(1));
        wait_idle();

        // all components at the negative extreme, biggest norm
        load_quat({1'b1, {(QUAT_W-1){1'b0}}}, {1'b1, {(QUAT_W-1){1'b0}}},
                  {1'b1, {(QUAT_W-1){1'b0}}}, {1'b1, {(QUAT_W-1){1'b0}}});
        send_vec(vmax, vmin, vmax);
        send_vec(vmin, vmin, vmax);
        send_vec(VEC_W'(3), VEC_W'(-5), VEC_W'(7));
        wait_idle();

        // 90 degrees about x with a tiny norm: negating the minimum component saturates
        load_quat(QUAT_W'(1), '0, '0, QUAT_W'(1));
        send_vec(vmax, vmax, vmin);
        send_vec(vmin, vmin, vmax);
        send_vec(VEC_W'(1), VEC_W'(-1), VEC_W'(1));
        wait_idle();

        // n = 4: each row is 4 times one component, so the divide is exact
        load_quat(QUAT_W'(1), QUAT_W'(1), QUAT_W'(1), QUAT_W'(1));
        send_vec(VEC_W'(1), VEC_W'(0), VEC_W'(0));
        send_vec(VEC_W'(-1), VEC_W'(2), VEC_W'(-3));
        send_vec(vmax, vmin, '0);
        wait_idle();

        // random phases, each under its own quaternion
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    qa = QUAT_W'($urandom);
                    qb = QUAT_W'($urandom);
                    qc = QUAT_W'($urandom);
                    qd = QUAT_W'($urandom);
                end
                1:
                begin
                    qa = QUAT_W'($urandom_range(0, 6) - 3);
                    qb = QUAT_W'($urandom_range(0, 6) - 3);
                    qc = QUAT_W'($urandom_range(0, 6) - 3);
                    qd = QUAT_W'($urandom_range(0, 6) - 3);
                end
                2:
                begin
                    qa = '0;
                    qb = '0;
                    qc = QUAT_W'(23170);
                    qd = QUAT_W'(23170);
                end
                default:
                begin
                    qa = QUAT_W'($urandom_range(0, 255) - 128);
                    qb = {1'b0, {(QUAT_W-1){1'b1}}};
                    qc = QUAT_W'($urandom);
                    qd = {1'b1, {(QUAT_W-1){1'b0}}};
                end
            endcase
            load_quat(qa, qb, qc, qd);

            // every third phase runs back to back; one phase fills the block
            no_gaps = (ph % 3 == 1);
            if (ph == 4)
            begin
                no_gaps = 1'b1;
                hold_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_vec(rand_comp(), rand_comp(), rand_comp());
            no_gaps = 1'b0;
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
